// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port checker of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the clock and muted while reset is held.
`define SKF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that also runs during reset.
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/core/skf_pkg.sv -----
// Shared types and constants of the scalar Kalman filter.
// Depends on nothing; used by the channel interfaces, the core and its checker.
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int GAIN_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(1 << FRAC_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = DATA_W'(262);
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = DATA_W'(65536);

  // The gain needs one integer quotient bit plus the fraction bits.
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PRED = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MULX = 6'b001000,
    ST_MULP = 6'b010000,
    ST_DONE = 6'b100000
  } skf_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/skf_meas_if.sv -----
// Measurement channel: valid/ready handshake carrying one sample z.
// Depends on skf_pkg for the data width.
`default_nettype none

interface skf_meas_if;
  logic                                valid;
  logic                                ready;
  logic signed [skf_pkg::DATA_W-1:0]   measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/skf_est_if.sv -----
// Result channel: valid/ready handshake carrying the estimate and the gain.
// Depends on skf_pkg for the field widths.
`default_nettype none

interface skf_est_if;
  logic                                valid;
  logic                                ready;
  logic signed [skf_pkg::DATA_W-1:0]   estimate;
  logic        [skf_pkg::GAIN_W-1:0]   gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink   (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/scalar_kalman_filter.sv -----
// Scalar Kalman filter, random-walk model, Q16.16 fixed point; uses skf_pkg and the channel ifs.
// A taken measurement runs through PRED, DIV, MULX, MULP and DONE; DONE loads the result beat.
// Ready stays low until DONE loads the result; the 17-step divider is the longest step.
// A finished result sits in an output register; the next item may start while it waits.
// Reset (synchronous, rst_n low): estimate and variance clear to zero, Q and R take
// their default values and the output channel goes empty.
`default_nettype none

module scalar_kalman_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  skf_meas_if.sink                        in_chan,
  skf_est_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]      cfg_wdata
);
  import skf_pkg::*;

  localparam logic [CNT_W-1:0] DivLast = CNT_W'(DIV_STEPS - 1);
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = DIFF_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int REM_W   = DIFF_W + 1;

  skf_state_t state_r, state_nxt;

  logic [DATA_W-1:0]         q_noise_r, r_noise_r;
  logic [DATA_W-1:0]         x_r, p_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic [DATA_W-1:0]         pm_r;
  logic [DIFF_W-1:0]         den_r;
  logic [REM_W-1:0]          rem_r;
  logic [GAIN_W-1:0]         quo_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [DATA_W-1:0]         xn_r;
  logic [DATA_W-1:0]         est_r;
  logic [GAIN_W-1:0]         gain_r;
  logic                      out_valid_r;

  logic                      in_acc;
  logic                      out_load;
  logic [DIFF_W-1:0]         sum_p;
  logic [DATA_W-1:0]         pm_sat;
  logic [DIFF_W-1:0]         den_sum;
  logic [REM_W:0]            trial;
  logic                      fits;
  logic [REM_W-1:0]          rem_sel;
  logic [GAIN_W-1:0]         k_val;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_out;
  logic [MUL_B_W-1:0]        xn_sum;

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign in_acc          = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.estimate = est_r;
  assign out_chan.gain     = gain_r;
  assign out_load        = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // Prediction with saturation, then the gain denominator held in 33 bits.
  assign sum_p   = {1'b0, p_r} + {1'b0, q_noise_r};
  assign pm_sat  = sum_p[DATA_W] ? {DATA_W{1'b1}} : sum_p[DATA_W-1:0];
  assign den_sum = {1'b0, pm_sat} + {1'b0, r_noise_r};

  // One restoring division step: compare, subtract if it fits, shift left.
  assign trial   = {1'b0, rem_r} - {2'b00, den_r};
  assign fits    = !trial[REM_W];
  assign rem_sel = fits ? trial[REM_W-1:0] : rem_r;

  // A zero denominator forces the gain to zero.
  assign k_val = (den_r == '0) ? '0 : quo_r;

  // Shared multiplier: k * (z - x) first, then (1 - k) * pm.
  always_comb begin
    if (state_r == ST_MULX) begin
      mul_a = $signed({1'b0, k_val});
      mul_b = $signed({diff_r[DIFF_W-1], diff_r});
    end else begin
      mul_a = $signed({1'b0, ONE_Q16 - k_val});
      mul_b = $signed({2'b00, pm_r});
    end
  end
  assign mul_out = mul_a * mul_b;

  // The arithmetic shift of the product floors toward minus infinity.
  assign xn_sum = {{(MUL_B_W-DATA_W){x_r[DATA_W-1]}}, x_r} + prod_r[FRAC_W +: MUL_B_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_PRED;
      ST_PRED: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == DivLast) state_nxt = ST_MULX;
      ST_MULX: state_nxt = ST_MULP;
      ST_MULP: state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_noise_r   <= PROCESS_NOISE_RST;
      r_noise_r   <= MEASURE_NOISE_RST;
      x_r         <= '0;
      p_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE: q_noise_r <= cfg_wdata;
          CFG_MEASURE_NOISE: r_noise_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == ST_PRED) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (out_load) begin
        x_r         <= xn_r;
        p_r         <= prod_r[FRAC_W +: DATA_W];
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          diff_r <= $signed({in_chan.measurement[DATA_W-1], in_chan.measurement})
                    - $signed({x_r[DATA_W-1], x_r});
        end
      end
      ST_PRED: begin
        pm_r  <= pm_sat;
        den_r <= den_sum;
        rem_r <= {2'b00, pm_sat};
        quo_r <= '0;
      end
      ST_DIV: begin
        rem_r <= {rem_sel[REM_W-2:0], 1'b0};
        quo_r <= {quo_r[GAIN_W-2:0], fits};
      end
      ST_MULX: begin
        prod_r <= mul_out;
      end
      ST_MULP: begin
        xn_r   <= xn_sum[DATA_W-1:0];
        prod_r <= mul_out;
      end
      ST_DONE: begin
        if (out_load) begin
          est_r  <= xn_r;
          gain_r <= k_val;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/skf_checker.sv -----
// Port-level checker of the scalar Kalman filter, bound to the top level.
// Depends on skf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module skf_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [skf_pkg::DATA_W-1:0]    out_estimate,
  input logic [skf_pkg::GAIN_W-1:0]    out_gain
);
  import skf_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // The core is busy right after it takes a measurement.
  `SKF_ASSERT(a_busy_after_beat, clk, rst_n, in_beat |=> !in_ready,
              "ready stayed high after an input beat")

  // A result needs many cycles, so it never appears right after an input beat.
  `SKF_ASSERT(a_no_early_result, clk, rst_n, in_beat |=> !$rose(out_valid),
              "result appeared one cycle after its input beat")

  // The gain never exceeds one.
  `SKF_ASSERT(a_gain_range, clk, rst_n, out_valid |-> (out_gain <= ONE_Q16), "gain above one")

  // A stalled result beat holds its payload.
  `SKF_ASSERT(a_out_hold, clk, rst_n,
              (out_valid && !out_ready) |=>
                (out_valid && $stable(out_estimate) && $stable(out_gain)),
              "stalled result changed")

  // Reset empties the result channel.
  `SKF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind scalar_kalman_filter skf_port_checker u_skf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_estimate (out_chan.estimate),
  .out_gain     (out_chan.gain)
);

`default_nettype wire

// ----- test/skf_checker.sv -----
// Checker for the scalar Kalman filter: watches both channels and the register
// port, predicts each result and compares it field by field. Uses skf_pkg and the
// measurement and result channel interfaces.
`default_nettype none

module skf_checker
  import skf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  skf_meas_if                  meas_chan,
  skf_est_if                   est_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0]        gain;
  } est_beat_t;

  // Filter state and noise settings as the block should hold them.
  logic signed [DATA_W-1:0] model_x;
  logic [DATA_W-1:0]        model_p;
  logic [DATA_W-1:0]        model_q;
  logic [DATA_W-1:0]        model_r;

  est_beat_t expected_estimates[$];

  // One filter step: predict the variance, form the gain, update x and p.
  function automatic est_beat_t kalman_update(input logic signed [DATA_W-1:0] z);
    logic [DATA_W:0]    p_sum;
    logic [DATA_W-1:0]  pm;
    logic [DATA_W:0]    den;
    longint unsigned    k;
    longint unsigned    p_next;
    longint             diff;
    longint             delta;
    longint             x_next;
    est_beat_t          beat;
    p_sum = {1'b0, model_p} + {1'b0, model_q};
    pm    = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    den   = {1'b0, pm} + {1'b0, model_r};
    if (den == '0) begin
      k = 0;
    end else begin
      k = (64'(pm) << FRAC_W) / 64'(den);
    end
    if (k > 64'd65536) begin
      k = 64'd65536;
    end
    diff   = longint'(z) - longint'(model_x);
    // Arithmetic shift of the signed product rounds toward minus infinity.
    delta  = (longint'(k) * diff) >>> FRAC_W;
    x_next = longint'(model_x) + delta;
    p_next = ((64'd65536 - k) * 64'(pm)) >> FRAC_W;
    model_x = x_next[DATA_W-1:0];
    model_p = p_next[DATA_W-1:0];
    beat.estimate = model_x;
    beat.gain     = k[GAIN_W-1:0];
    return beat;
  endfunction

  function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s: expected 0x%h, got 0x%h", $realtime, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    est_beat_t want;
    if (!rst_n) begin
      model_x = '0;
      model_p = '0;
      model_q = PROCESS_NOISE_RST;
      model_r = MEASURE_NOISE_RST;
      expected_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE: model_q = cfg_wdata;
          CFG_MEASURE_NOISE: model_r = cfg_wdata;
          default: ;
        endcase
      end
      if (meas_chan.valid && meas_chan.ready) begin
        expected_estimates.push_back(kalman_update(meas_chan.measurement));
      end
      if (est_chan.valid && est_chan.ready) begin
        if (expected_estimates.size() == 0) begin
          note_mismatch("result beat with nothing expected", '0, est_chan.estimate);
        end else begin
          want = expected_estimates.pop_front();
          if (est_chan.estimate !== want.estimate) begin
            note_mismatch("estimate", want.estimate, est_chan.estimate);
          end
          if (est_chan.gain !== want.gain) begin
            note_mismatch("gain", DATA_W'(want.gain), DATA_W'(est_chan.gain));
          end
        end
      end
    end
    pending = expected_estimates.size();
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench top for the scalar Kalman filter: drives measurements, noise settings
// and result back-pressure, and gives the verdict. Prediction and comparison live
// in skf_checker; uses skf_pkg and the two channel interfaces.
`default_nettype none

module tb;
  import skf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;
  int                   mismatches;
  int                   pending;
  bit                   no_idle;
  logic signed [DATA_W-1:0] truth;

  skf_meas_if meas_chan();
  skf_est_if  est_chan();

  scalar_kalman_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (meas_chan),
    .out_chan  (est_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  skf_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .meas_chan  (meas_chan),
    .est_chan   (est_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("scalar_kalman_filter regression: fail");
    $finish;
  end

  // Result side: before each beat, hold ready low for a random stall, maybe none.
  initial begin
    int stall;
    est_chan.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        est_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      est_chan.ready <= 1'b1;
      do @(posedge clk); while (!(est_chan.valid && est_chan.ready));
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_sample(input logic signed [DATA_W-1:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      meas_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    meas_chan.valid       <= 1'b1;
    meas_chan.measurement <= z;
    do @(posedge clk); while (!(meas_chan.valid && meas_chan.ready));
    @(negedge clk);
  endtask

  task automatic drain_results();
    meas_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Rewrites both noise registers while the filter is idle, in random order,
  // optionally with a write to an unmapped index that must be ignored.
  task automatic set_noise(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                           input bit stray);
    bit q_first;
    q_first = $urandom_range(0, 1);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= q_first ? CFG_PROCESS_NOISE : CFG_MEASURE_NOISE;
    cfg_wdata <= q_first ? q : r;
    @(negedge clk);
    cfg_index <= q_first ? CFG_MEASURE_NOISE : CFG_PROCESS_NOISE;
    cfg_wdata <= q_first ? r : q;
    @(negedge clk);
    if (stray) begin
      cfg_index <= CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1));
      cfg_wdata <= $urandom;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DATA_W'($urandom_range(0, 255));
      3: return DATA_W'($urandom_range(0, 32'h0004_0000));
      4: return DATA_W'($urandom);
      default: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    endcase
  endfunction

  // Half drifting signal with bounded noise, half raw, extreme or small samples.
  function automatic logic signed [DATA_W-1:0] pick_measurement();
    int unsigned spread;
    spread = 32'd1 << $urandom_range(8, 22);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
        truth = truth + DATA_W'($signed($urandom_range(0, 2048)) - 1024);
        return truth + DATA_W'($signed(int'($urandom_range(0, spread))) - int'(spread / 2));
      end
      10, 11, 12, 13, 14: return $urandom;
      15: return 32'sh7FFF_FFFF;
      16: return 32'sh8000_0000;
      17: return $signed(DATA_W'($urandom_range(0, 3))) - 1;
      default: return DATA_W'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
    endcase
  endfunction

  initial begin
    int sent;
    int phase_len;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    meas_chan.valid       = 1'b0;
    meas_chan.measurement = '0;
    no_idle               = 1'b0;
    truth                 = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default noise settings, extreme measurements in both directions.
    send_sample(32'sh0000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    // Largest noise: the variance prediction saturates.
    set_noise('1, '1, 1'b0);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000);
    // No measurement noise: full gain, estimate jumps to z, variance clears.
    set_noise('1, '0, 1'b1);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    // No noise at all and zero variance: the denominator is zero.
    set_noise('0, '0, 1'b0);
    send_sample(32'sd12345);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    // Huge measurement noise: the gain rounds down to zero.
    set_noise('0, '1, 1'b1);
    send_sample(32'sh7FFF_FFFF);
    set_noise(32'd1, '1, 1'b0);
    send_sample(32'sh8000_0000);
    no_idle = 1'b1;
    set_noise(32'd65536, 32'd65536, 1'b0);
    send_sample(32'sh0001_0000);
    send_sample(-32'sh0001_0000);
    send_sample(32'sh0000_8000);

    sent = 0;
    while (sent < 1100) begin
      phase_len = $urandom_range(40, 160);
      set_noise(pick_noise(), pick_noise(), $urandom_range(0, 3) == 0);
      no_idle = $urandom_range(0, 3) == 0;
      truth   = $urandom;
      repeat (phase_len) begin
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end
        send_sample(pick_measurement());
        sent++;
      end
    end

    drain_results();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("scalar_kalman_filter regression: pass");
    end else begin
      $display("scalar_kalman_filter regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
